// File: rtl/aavr_pkg.sv
// ----------------------------------------------------------------------------
// Axis-angle rotation package
// Shared widths, fixed-point constants, the arctangent table and helpers.
// ----------------------------------------------------------------------------
package aavr_pkg;

  localparam int unsigned Q_W       = 34;  // Q2.30 working width with headroom
  localparam int unsigned Z_W       = 36;  // angle reduction width
  localparam int unsigned ANGLE_W   = 32;
  localparam int unsigned MAG_W     = 32;
  localparam int unsigned RAD_W     = 64;
  localparam int unsigned ROOT_W    = 32;
  localparam int unsigned QUO_W     = 31;
  localparam int unsigned R_W       = 32;
  localparam int unsigned NORM_CELLS = 6;
  localparam int unsigned NORM_STEP [NORM_CELLS] = '{16, 8, 4, 2, 1, 1};

  typedef logic signed [Q_W-1:0] q_t;
  typedef logic signed [R_W-1:0] r_t;

  localparam q_t ONE_Q30 = 34'sd1073741824;
  localparam q_t GAIN_Q30 = 34'sd652032874;
  localparam logic signed [Z_W-1:0] Z_HALF_PI = 36'sd1686629713;
  localparam logic signed [Z_W-1:0] Z_PI      = 36'sd3373259426;
  localparam logic signed [Z_W-1:0] Z_TWO_PI  = 36'sd6746518852;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837830, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516, 32'd16775851, 32'd8388437, 32'd4194283, 32'd2097149,
    32'd1048576, 32'd524288, 32'd262144, 32'd131072, 32'd65536, 32'd32768,
    32'd16384, 32'd8192, 32'd4096, 32'd2048, 32'd1024, 32'd512, 32'd256,
    32'd128, 32'd64, 32'd32, 32'd16, 32'd8, 32'd4, 32'd2, 32'd1, 32'd0
  };

  function automatic q_t mul_q30(q_t a, q_t b);
    logic signed [2*Q_W-1:0] pr;
    pr = (a * b) + $signed({{(2*Q_W-30){1'b0}}, 1'b1, 29'd0});
    return pr[Q_W+29:30];
  endfunction

  function automatic r_t clamp_q30(logic signed [Q_W:0] v);
    if (v > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[R_W-1:0];
  endfunction

endpackage

// File: rtl/axis_angle_vector_rotation.sv
// ----------------------------------------------------------------------------
// Axis-angle vector rotation
// Rotates a vector about an axis of any length by the Rodrigues formula.
// ----------------------------------------------------------------------------
// Accepts one beat per clock while the result side is not stalled and delivers
// each result in order through 81 register stages. The depth is set by the cell
// chains: six normaliser cells, 32 square root cells, 31 divider cells (one per
// quotient bit) and then a short multiply and sum pipeline; the CORDIC chain of
// CORDIC_STAGES cells runs alongside and its sine and cosine are delayed to
// meet the unit axis. A stalled result holds the whole pipeline; bubbles are
// carried along.
module axis_angle_vector_rotation
  import aavr_pkg::*;
#(
  parameter int unsigned COMPONENT_WIDTH = 32,
  parameter int unsigned CORDIC_STAGES   = 24
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COMPONENT_WIDTH-1:0] vec_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] vec_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] vec_z_i,
  input  logic signed [COMPONENT_WIDTH-1:0] axis_x_i,
  input  logic signed [COMPONENT_WIDTH-1:0] axis_y_i,
  input  logic signed [COMPONENT_WIDTH-1:0] axis_z_i,
  input  logic signed [ANGLE_W-1:0]         angle_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [COMPONENT_WIDTH-1:0] out_x_o,
  output logic signed [COMPONENT_WIDTH-1:0] out_y_o,
  output logic signed [COMPONENT_WIDTH-1:0] out_z_o,
  output logic                              zero_axis_o,
  output logic                              overflowed_o
);

  localparam int unsigned CW      = COMPONENT_WIDTH;
  localparam int unsigned CS      = CORDIC_STAGES;
  localparam int unsigned MW      = (CW > MAG_W) ? CW : MAG_W;
  localparam int unsigned STAGES  = 81;
  localparam int unsigned FLG_DLY = 79;
  localparam int unsigned SGN_TAP = 71;
  localparam int unsigned VEC_DLY = 76;
  localparam int unsigned MAG_DLY = 34;
  localparam int unsigned CS_DLY  = 70 - CS;
  localparam int unsigned LO      = CW / 2;
  localparam int unsigned HW      = CW - LO;
  localparam int unsigned PLW     = R_W + LO + 1;
  localparam int unsigned PHW     = R_W + HW;
  localparam int unsigned PW      = R_W + CW;
  localparam int unsigned ACC_W   = PW + 2;
  localparam int unsigned RW      = ACC_W - 29;
  localparam logic signed [RW-1:0] VMAX = RW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] VMIN = -VMAX - RW'(1);

  logic adv;
  logic vld_q [STAGES];

  assign adv         = !(vld_q[STAGES-1] && out_stall_i);
  assign in_stall_o  = !adv;
  assign out_valid_o = vld_q[STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STAGES; k++) vld_q[k] <= 1'b0;
    end else if (adv) begin
      vld_q[0] <= in_valid_i;
      for (int k = 1; k < STAGES; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  // input beat
  logic [2:0][CW-1:0]   vec_q, axis_q;
  logic [ANGLE_W-1:0]   angle_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vec_q   <= {vec_z_i, vec_y_i, vec_x_i};
      axis_q  <= {axis_z_i, axis_y_i, axis_x_i};
      angle_q <= angle_i;
    end
  end

  // magnitudes, largest, flags
  logic [2:0][MW-1:0] mag1;
  logic [MW-1:0]      mx1;
  logic [3:0]         flg1;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag1[k] = MW'(axis_q[k][CW-1] ? (~axis_q[k] + 1'b1) : axis_q[k]);
    end
    mx1 = mag1[0];
    if (mag1[1] > mx1) mx1 = mag1[1];
    if (mag1[2] > mx1) mx1 = mag1[2];
    flg1 = {mx1 == '0, axis_q[2][CW-1], axis_q[1][CW-1], axis_q[0][CW-1]};
  end

  logic [3:0]         flg_q [FLG_DLY];
  logic [2:0][CW-1:0] vd_q  [VEC_DLY];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      flg_q[0] <= flg1;
      for (int k = 1; k < FLG_DLY; k++) flg_q[k] <= flg_q[k-1];
      vd_q[0] <= vec_q;
      for (int k = 1; k < VEC_DLY; k++) vd_q[k] <= vd_q[k-1];
    end
  end

  // normaliser chain
  logic [MW-1:0]      norm_cur [NORM_CELLS+1];
  logic [2:0][MW-1:0] norm_mag [NORM_CELLS+1];

  assign norm_cur[0] = mx1;
  assign norm_mag[0] = mag1;

  for (genvar k = 0; k < NORM_CELLS; k++) begin : g_norm
    aavr_norm_cell #(
      .MW    (MW),
      .SHIFT (NORM_STEP[k]),
      .FINAL (k == NORM_CELLS - 1)
    ) u_cell (
      .clk_i (clk_i),
      .ena_i (adv),
      .cur_i (norm_cur[k]),
      .mag_i (norm_mag[k]),
      .cur_o (norm_cur[k+1]),
      .mag_o (norm_mag[k+1])
    );
  end

  // squares and their sum
  logic [2:0][MAG_W-1:0] mag7;
  logic [2:0][RAD_W-1:0] sq_q;
  logic [RAD_W-1:0]      n2_q;
  logic [2:0][MAG_W-1:0] magd_q [MAG_DLY];

  always_comb begin
    for (int k = 0; k < 3; k++) mag7[k] = norm_mag[NORM_CELLS][k][MAG_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) sq_q[k] <= RAD_W'(mag7[k]) * RAD_W'(mag7[k]);
      n2_q <= sq_q[0] + sq_q[1] + sq_q[2];
      magd_q[0] <= mag7;
      for (int k = 1; k < MAG_DLY; k++) magd_q[k] <= magd_q[k-1];
    end
  end

  // square root chain
  logic [RAD_W-1:0]  sr_rem  [ROOT_W+1];
  logic [ROOT_W-1:0] sr_root [ROOT_W+1];

  assign sr_rem[0]  = n2_q;
  assign sr_root[0] = '0;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
    aavr_sqrt_cell #(
      .BIT (ROOT_W - 1 - k)
    ) u_cell (
      .clk_i  (clk_i),
      .ena_i  (adv),
      .rem_i  (sr_rem[k]),
      .root_i (sr_root[k]),
      .rem_o  (sr_rem[k+1]),
      .root_o (sr_root[k+1])
    );
  end

  // dividend set-up and divider chain
  logic [2:0][RAD_W-1:0] dv_rem  [QUO_W+1];
  logic [2:0][QUO_W-1:0] dv_quo  [QUO_W+1];
  logic [ROOT_W-1:0]     dv_den  [QUO_W+1];
  logic [2:0][RAD_W-1:0] dvs_q;
  logic [ROOT_W-1:0]     den_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      den_q <= sr_root[ROOT_W];
      for (int k = 0; k < 3; k++) begin
        dvs_q[k] <= ({32'd0, magd_q[MAG_DLY-1][k]} << 30)
                  + {33'd0, sr_root[ROOT_W][ROOT_W-1:1]};
      end
    end
  end

  assign dv_rem[0] = dvs_q;
  assign dv_quo[0] = '0;
  assign dv_den[0] = den_q;

  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    aavr_div_cell #(
      .BIT (QUO_W - 1 - k)
    ) u_cell (
      .clk_i (clk_i),
      .ena_i (adv),
      .den_i (dv_den[k]),
      .rem_i (dv_rem[k]),
      .quo_i (dv_quo[k]),
      .den_o (dv_den[k+1]),
      .rem_o (dv_rem[k+1]),
      .quo_o (dv_quo[k+1])
    );
  end

  // angle reduction and CORDIC chain
  logic signed [Z_W-1:0] za, z2_q;
  q_t                    z3_q;
  logic                  flip3_q;

  assign za = {{(Z_W-ANGLE_W-2){angle_q[ANGLE_W-1]}}, angle_q, 2'b00};

  always_ff @(posedge clk_i) begin
    if (adv) begin
      priority if (za > Z_PI) begin
        z2_q <= za - Z_TWO_PI;
      end else if (za < -Z_PI) begin
        z2_q <= za + Z_TWO_PI;
      end else begin
        z2_q <= za;
      end
      priority if (z2_q > Z_HALF_PI) begin
        z3_q    <= q_t'(z2_q - Z_PI);
        flip3_q <= 1'b1;
      end else if (z2_q < -Z_HALF_PI) begin
        z3_q    <= q_t'(z2_q + Z_PI);
        flip3_q <= 1'b1;
      end else begin
        z3_q    <= q_t'(z2_q);
        flip3_q <= 1'b0;
      end
    end
  end

  q_t   cx [CS+1];
  q_t   cy [CS+1];
  q_t   cz [CS+1];
  logic cf [CS+1];

  assign cx[0] = GAIN_Q30;
  assign cy[0] = '0;
  assign cz[0] = z3_q;
  assign cf[0] = flip3_q;

  for (genvar k = 0; k < CS; k++) begin : g_cordic
    aavr_cordic_cell #(
      .STAGE (k)
    ) u_cell (
      .clk_i  (clk_i),
      .ena_i  (adv),
      .x_i    (cx[k]),
      .y_i    (cy[k]),
      .z_i    (cz[k]),
      .flip_i (cf[k]),
      .x_o    (cx[k+1]),
      .y_o    (cy[k+1]),
      .z_o    (cz[k+1]),
      .flip_o (cf[k+1])
    );
  end

  q_t cos_q, sin_q;
  q_t cosd_q [CS_DLY];
  q_t sind_q [CS_DLY];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cos_q <= cf[CS] ? -cx[CS] : cx[CS];
      sin_q <= cf[CS] ? -cy[CS] : cy[CS];
      cosd_q[0] <= cos_q;
      sind_q[0] <= sin_q;
      for (int k = 1; k < CS_DLY; k++) begin
        cosd_q[k] <= cosd_q[k-1];
        sind_q[k] <= sind_q[k-1];
      end
    end
  end

  // unit axis, matrix and product
  q_t                   u_q [3];
  q_t                   p_q [6];
  q_t                   m_q [6];
  q_t                   us_q [3];
  q_t                   us2_q [3];
  q_t                   t_q, c1_q, c2_q;
  r_t                   rc_q [9];
  logic signed [PHW-1:0] ph_q [9];
  logic signed [PLW-1:0] pl_q [9];
  logic signed [PW-1:0]  pr_q [9];
  logic signed [ACC_W-1:0] acc_q [3];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        u_q[k] <= flg_q[SGN_TAP][k] ? -q_t'({3'b000, dv_quo[QUO_W][k]})
                                    :  q_t'({3'b000, dv_quo[QUO_W][k]});
      end
      p_q[0] <= mul_q30(u_q[0], u_q[0]);
      p_q[1] <= mul_q30(u_q[1], u_q[1]);
      p_q[2] <= mul_q30(u_q[2], u_q[2]);
      p_q[3] <= mul_q30(u_q[0], u_q[1]);
      p_q[4] <= mul_q30(u_q[0], u_q[2]);
      p_q[5] <= mul_q30(u_q[1], u_q[2]);
      for (int k = 0; k < 3; k++) us_q[k] <= mul_q30(u_q[k], sind_q[CS_DLY-1]);
      t_q  <= ONE_Q30 - cosd_q[CS_DLY-1];
      c1_q <= cosd_q[CS_DLY-1];

      for (int k = 0; k < 6; k++) m_q[k] <= mul_q30(p_q[k], t_q);
      us2_q <= us_q;
      c2_q  <= c1_q;

      rc_q[0] <= clamp_q30(c2_q + m_q[0]);
      rc_q[4] <= clamp_q30(c2_q + m_q[1]);
      rc_q[8] <= clamp_q30(c2_q + m_q[2]);
      rc_q[1] <= clamp_q30(m_q[3] - us2_q[2]);
      rc_q[3] <= clamp_q30(m_q[3] + us2_q[2]);
      rc_q[2] <= clamp_q30(m_q[4] + us2_q[1]);
      rc_q[6] <= clamp_q30(m_q[4] - us2_q[1]);
      rc_q[5] <= clamp_q30(m_q[5] - us2_q[0]);
      rc_q[7] <= clamp_q30(m_q[5] + us2_q[0]);

      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          ph_q[3*i+j] <= rc_q[3*i+j] * $signed(vd_q[VEC_DLY-1][j][CW-1:LO]);
          pl_q[3*i+j] <= rc_q[3*i+j] * $signed({1'b0, vd_q[VEC_DLY-1][j][LO-1:0]});
        end
      end

      for (int k = 0; k < 9; k++) pr_q[k] <= (ph_q[k] <<< LO) + pl_q[k];

      for (int i = 0; i < 3; i++) begin
        acc_q[i] <= (pr_q[3*i] >>> 1) + (pr_q[3*i+1] >>> 1) + (pr_q[3*i+2] >>> 1);
      end
    end
  end

  // round, saturate, hold the result beat
  logic signed [ACC_W-1:0] rnd [3];
  logic signed [RW-1:0]    res [3];
  logic [2:0][CW-1:0]      out_d;
  logic [2:0]              sat;
  logic [2:0][CW-1:0]      out_q;
  logic                    zero_q, ovf_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = acc_q[i] + $signed({{(ACC_W-29){1'b0}}, 1'b1, 28'd0});
      res[i] = rnd[i][ACC_W-1:29];
      if (res[i] > VMAX) begin
        out_d[i] = VMAX[CW-1:0];
        sat[i]   = 1'b1;
      end else if (res[i] < VMIN) begin
        out_d[i] = VMIN[CW-1:0];
        sat[i]   = 1'b1;
      end else begin
        out_d[i] = res[i][CW-1:0];
        sat[i]   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (flg_q[FLG_DLY-1][3]) begin
        out_q  <= '0;
        zero_q <= 1'b1;
        ovf_q  <= 1'b0;
      end else begin
        out_q  <= out_d;
        zero_q <= 1'b0;
        ovf_q  <= |sat;
      end
    end
  end

  assign out_x_o      = out_q[0];
  assign out_y_o      = out_q[1];
  assign out_z_o      = out_q[2];
  assign zero_axis_o  = zero_q;
  assign overflowed_o = ovf_q;

endmodule

// File: rtl/aavr_norm_cell.sv
// ----------------------------------------------------------------------------
// Axis normaliser cell
// One step of the power-of-two scaling that brings the largest axis magnitude
// into [2^30, 2^31].
// ----------------------------------------------------------------------------
module aavr_norm_cell #(
  parameter int unsigned MW    = 32,
  parameter int unsigned SHIFT = 1,
  parameter bit          FINAL = 1'b0
) (
  input  logic                clk_i,
  input  logic                ena_i,
  input  logic [MW-1:0]       cur_i,
  input  logic [2:0][MW-1:0]  mag_i,
  output logic [MW-1:0]       cur_o,
  output logic [2:0][MW-1:0]  mag_o
);

  localparam logic [MW-1:0] TOP = MW'(64'd1 << 31);
  localparam logic [MW-1:0] BOT = MW'(64'd1 << 30);

  logic               go_r, go_l;
  logic [MW-1:0]      cur_d, cur_q;
  logic [2:0][MW-1:0] mag_d, mag_q;

  assign go_r = FINAL ? (cur_i > TOP) : ((cur_i >> SHIFT) > TOP);
  assign go_l = FINAL ? (cur_i < BOT) : (cur_i < (BOT >> SHIFT));

  always_comb begin
    if (go_r) begin
      cur_d = cur_i >> SHIFT;
      for (int k = 0; k < 3; k++) mag_d[k] = mag_i[k] >> SHIFT;
    end else if (go_l) begin
      cur_d = cur_i << SHIFT;
      for (int k = 0; k < 3; k++) mag_d[k] = mag_i[k] << SHIFT;
    end else begin
      cur_d = cur_i;
      mag_d = mag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ena_i) begin
      cur_q <= cur_d;
      mag_q <= mag_d;
    end
  end

  assign cur_o = cur_q;
  assign mag_o = mag_q;

endmodule

// File: rtl/aavr_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Square root cell
// Settles one bit of the integer square root of the squared axis length.
// ----------------------------------------------------------------------------
module aavr_sqrt_cell
  import aavr_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  logic              clk_i,
  input  logic              ena_i,
  input  logic [RAD_W-1:0]  rem_i,
  input  logic [ROOT_W-1:0] root_i,
  output logic [RAD_W-1:0]  rem_o,
  output logic [ROOT_W-1:0] root_o
);

  logic [RAD_W+1:0]  trial;
  logic [RAD_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;

  assign trial = ({34'd0, root_i} << (BIT + 1)) | (66'd1 << (2 * BIT));

  always_ff @(posedge clk_i) begin
    if (ena_i) begin
      if ({2'b00, rem_i} >= trial) begin
        rem_q  <= rem_i - trial[RAD_W-1:0];
        root_q <= root_i | (32'd1 << BIT);
      end else begin
        rem_q  <= rem_i;
        root_q <= root_i;
      end
    end
  end

  assign rem_o  = rem_q;
  assign root_o = root_q;

endmodule

// File: rtl/aavr_div_cell.sv
// ----------------------------------------------------------------------------
// Divider cell
// Settles one quotient bit of the three unit-axis divisions by the norm.
// ----------------------------------------------------------------------------
module aavr_div_cell
  import aavr_pkg::*;
#(
  parameter int unsigned BIT = 0
) (
  input  logic                   clk_i,
  input  logic                   ena_i,
  input  logic [ROOT_W-1:0]      den_i,
  input  logic [2:0][RAD_W-1:0]  rem_i,
  input  logic [2:0][QUO_W-1:0]  quo_i,
  output logic [ROOT_W-1:0]      den_o,
  output logic [2:0][RAD_W-1:0]  rem_o,
  output logic [2:0][QUO_W-1:0]  quo_o
);

  logic [RAD_W-1:0]        comp;
  logic [ROOT_W-1:0]       den_q;
  logic [2:0][RAD_W-1:0]   rem_q;
  logic [2:0][QUO_W-1:0]   quo_q;

  assign comp = {32'd0, den_i} << BIT;

  always_ff @(posedge clk_i) begin
    if (ena_i) begin
      den_q <= den_i;
      for (int k = 0; k < 3; k++) begin
        if (rem_i[k] >= comp) begin
          rem_q[k] <= rem_i[k] - comp;
          quo_q[k] <= quo_i[k] | (31'd1 << BIT);
        end else begin
          rem_q[k] <= rem_i[k];
          quo_q[k] <= quo_i[k];
        end
      end
    end
  end

  assign den_o = den_q;
  assign rem_o = rem_q;
  assign quo_o = quo_q;

endmodule

// File: rtl/aavr_cordic_cell.sv
// ----------------------------------------------------------------------------
// CORDIC cell
// One rotation-mode micro-rotation towards the residual angle.
// ----------------------------------------------------------------------------
module aavr_cordic_cell
  import aavr_pkg::*;
#(
  parameter int unsigned STAGE = 0
) (
  input  logic clk_i,
  input  logic ena_i,
  input  q_t   x_i,
  input  q_t   y_i,
  input  q_t   z_i,
  input  logic flip_i,
  output q_t   x_o,
  output q_t   y_o,
  output q_t   z_o,
  output logic flip_o
);

  localparam q_t ATAN = q_t'(ATAN_Q30[STAGE]);

  q_t   x_q, y_q, z_q;
  logic flip_q;

  always_ff @(posedge clk_i) begin
    if (ena_i) begin
      flip_q <= flip_i;
      if (z_i >= 0) begin
        x_q <= x_i - (y_i >>> STAGE);
        y_q <= y_i + (x_i >>> STAGE);
        z_q <= z_i - ATAN;
      end else begin
        x_q <= x_i + (y_i >>> STAGE);
        y_q <= y_i - (x_i >>> STAGE);
        z_q <= z_i + ATAN;
      end
    end
  end

  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;
  assign flip_o = flip_q;

endmodule

// File: tb/rotation_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle rotation checker
// Watches both channels, predicts each rotated vector from the accepted input
// beat and compares it field by field with the beats that leave the block.
// ----------------------------------------------------------------------------
module rotation_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic signed [31:0] vec_x_i,
  input  logic signed [31:0] vec_y_i,
  input  logic signed [31:0] vec_z_i,
  input  logic signed [31:0] axis_x_i,
  input  logic signed [31:0] axis_y_i,
  input  logic signed [31:0] axis_z_i,
  input  logic signed [31:0] angle_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [31:0] out_x_i,
  input  logic signed [31:0] out_y_i,
  input  logic signed [31:0] out_z_i,
  input  logic               zero_axis_i,
  input  logic               overflowed_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               zero_axis;
    logic               overflowed;
  } rotated_t;

  localparam int STAGES = 24;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint PI = 64'sd3373259426;
  localparam longint TWO_PI = 64'sd6746518852;
  localparam longint START_X = 64'sd652032874;
  localparam longint ONE_Q30 = 64'sd1073741824;

  localparam longint ARCTAN [STAGES] = '{
    843314857, 497837830, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128
  };

  rotated_t rotated_q[$];

  function automatic longint qmul(longint a, longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  function automatic longint entry_clamp(longint e);
    if (e > 2 * ONE_Q30 - 1) return 2 * ONE_Q30 - 1;
    if (e < -2 * ONE_Q30) return -2 * ONE_Q30;
    return e;
  endfunction

  function automatic rotated_t rotate_vector(longint vx, longint vy, longint vz,
                                             longint ax, longint ay, longint az,
                                             longint ang);
    longint v [3];
    longint a [3];
    longint u [3];
    longint r [3][3];
    longint unsigned mag [3];
    longint unsigned mx, n2, nrm, rem, bitv, q;
    longint c, s, t, z, x, y, nx, acc, res;
    bit flip;
    rotated_t o;
    v = '{vx, vy, vz};
    a = '{ax, ay, az};
    o = '0;
    for (int i = 0; i < 3; i++) mag[i] = a[i] < 0 ? -a[i] : a[i];
    mx = mag[0];
    if (mag[1] > mx) mx = mag[1];
    if (mag[2] > mx) mx = mag[2];
    if (mx == 0) begin
      o.zero_axis = 1'b1;
      return o;
    end
    while (mx > (64'd1 << 31)) begin
      mx >>= 1;
      for (int i = 0; i < 3; i++) mag[i] >>= 1;
    end
    while (mx < (64'd1 << 30)) begin
      mx <<= 1;
      for (int i = 0; i < 3; i++) mag[i] <<= 1;
    end
    n2 = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    rem = n2;
    nrm = 0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= nrm + bitv) begin
        rem = rem - (nrm + bitv);
        nrm = (nrm >> 1) + bitv;
      end else begin
        nrm >>= 1;
      end
      bitv >>= 2;
    end
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << 30) + (nrm >> 1)) / nrm;
      u[i] = a[i] < 0 ? -longint'(q) : longint'(q);
    end
    z = ang * 4;
    x = START_X;
    y = 0;
    flip = 1'b0;
    if (z > PI) z -= TWO_PI;
    if (z < -PI) z += TWO_PI;
    if (z > HALF_PI) begin
      z -= PI;
      flip = 1'b1;
    end else if (z < -HALF_PI) begin
      z += PI;
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= ARCTAN[i];
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += ARCTAN[i];
      end
      x = nx;
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
    t = ONE_Q30 - c;
    r[0][0] = c + qmul(qmul(u[0], u[0]), t);
    r[1][1] = c + qmul(qmul(u[1], u[1]), t);
    r[2][2] = c + qmul(qmul(u[2], u[2]), t);
    r[0][1] = qmul(qmul(u[0], u[1]), t) - qmul(u[2], s);
    r[1][0] = qmul(qmul(u[0], u[1]), t) + qmul(u[2], s);
    r[0][2] = qmul(qmul(u[0], u[2]), t) + qmul(u[1], s);
    r[2][0] = qmul(qmul(u[0], u[2]), t) - qmul(u[1], s);
    r[1][2] = qmul(qmul(u[1], u[2]), t) - qmul(u[0], s);
    r[2][1] = qmul(qmul(u[1], u[2]), t) + qmul(u[0], s);
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 3; j++) acc += (entry_clamp(r[i][j]) * v[j]) >>> 1;
      res = (acc + (64'sd1 <<< 28)) >>> 29;
      if (res > 64'sd2147483647) begin
        res = 64'sd2147483647;
        o.overflowed = 1'b1;
      end
      if (res < -64'sd2147483648) begin
        res = -64'sd2147483648;
        o.overflowed = 1'b1;
      end
      case (i)
        0: o.x = res[31:0];
        1: o.y = res[31:0];
        default: o.z = res[31:0];
      endcase
    end
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rotated_t want;
    if (!rst_ni) begin
      fail_count_o <= 0;
      pending_o <= 0;
      rotated_q.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        rotated_q.push_back(rotate_vector(vec_x_i, vec_y_i, vec_z_i, axis_x_i, axis_y_i,
                                          axis_z_i, angle_i));
      end
      if (out_valid_i && !out_stall_i) begin
        if (rotated_q.size() == 0) begin
          $error("result beat with no expectation waiting");
          fail_count_o <= fail_count_o + 1;
        end else begin
          want = rotated_q.pop_front();
          if (out_x_i !== want.x || out_y_i !== want.y || out_z_i !== want.z ||
              zero_axis_i !== want.zero_axis || overflowed_i !== want.overflowed) begin
            fail_count_o <= fail_count_o + 1;
          end
          if (out_x_i !== want.x) $error("out_x: expected %0d, got %0d", want.x, out_x_i);
          if (out_y_i !== want.y) $error("out_y: expected %0d, got %0d", want.y, out_y_i);
          if (out_z_i !== want.z) $error("out_z: expected %0d, got %0d", want.z, out_z_i);
          if (zero_axis_i !== want.zero_axis)
            $error("zero_axis: expected %0b, got %0b", want.zero_axis, zero_axis_i);
          if (overflowed_i !== want.overflowed)
            $error("overflowed: expected %0b, got %0b", want.overflowed, overflowed_i);
        end
      end
      pending_o <= rotated_q.size();
    end
  end

endmodule

// File: tb/tb_axis_angle_vector_rotation.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis-angle vector rotation testbench
// Drives directed corner beats and then bursts of random rotations with random
// gaps, stalls the result side on its own pattern including one long hold-off,
// and gives the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_axis_angle_vector_rotation;

  localparam int RANDOM_BEATS = 1750;
  localparam int IDLE_LIMIT = 5000;
  localparam logic signed [31:0] MAX_C = 32'sh7fffffff;
  localparam logic signed [31:0] MIN_C = 32'sh80000000;
  localparam logic signed [31:0] ONE_Q16 = 32'sh00010000;
  localparam logic signed [31:0] ANG_HALF_PI = 32'sd421657428;
  localparam logic signed [31:0] ANG_PI = 32'sd843314857;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] vec_x = '0, vec_y = '0, vec_z = '0;
  logic signed [31:0] axis_x = '0, axis_y = '0, axis_z = '0;
  logic signed [31:0] angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_x, out_y, out_z;
  logic zero_axis, overflowed;
  int fail_count, pending;
  int idle_cycles = 0;
  int cycle_count = 0;
  int burst_left = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  axis_angle_vector_rotation i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .vec_x_i(vec_x), .vec_y_i(vec_y), .vec_z_i(vec_z),
    .axis_x_i(axis_x), .axis_y_i(axis_y), .axis_z_i(axis_z), .angle_i(angle),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_x_o(out_x), .out_y_o(out_y), .out_z_o(out_z),
    .zero_axis_o(zero_axis), .overflowed_o(overflowed)
  );

  rotation_checker i_checker (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .vec_x_i(vec_x), .vec_y_i(vec_y), .vec_z_i(vec_z),
    .axis_x_i(axis_x), .axis_y_i(axis_y), .axis_z_i(axis_z), .angle_i(angle),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_x_i(out_x), .out_y_i(out_y), .out_z_i(out_z),
    .zero_axis_i(zero_axis), .overflowed_i(overflowed),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // result side: stall mode rotates through four patterns, with one long hold-off
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= 1500 && cycle_count < 1900) begin
      out_stall <= 1'b1;
    end else begin
      case ((cycle_count / 64) % 4)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(9) < 3);
        2: out_stall <= ($urandom_range(9) < 7);
        default: out_stall <= ($urandom_range(1) == 1);
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_beat(logic signed [31:0] vx, logic signed [31:0] vy,
                           logic signed [31:0] vz, logic signed [31:0] ax,
                           logic signed [31:0] ay, logic signed [31:0] az,
                           logic signed [31:0] ang);
    in_valid <= 1'b1;
    vec_x <= vx;
    vec_y <= vy;
    vec_z <= vz;
    axis_x <= ax;
    axis_y <= ay;
    axis_z <= az;
    angle <= ang;
    do @(posedge clk_i); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(24);
      if ($urandom_range(3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
  endtask

  function automatic logic signed [31:0] rand_axis(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 2 * 65536)) - 65536;
      2: return $signed($urandom_range(0, 6)) - 3;
      default: return 32'sd0;
    endcase
  endfunction

  initial begin
    int mode;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_beat(ONE_Q16, ONE_Q16, ONE_Q16, 0, 0, 0, ANG_HALF_PI);
    send_beat(MAX_C, MAX_C, MAX_C, 0, 0, ONE_Q16, ANG_HALF_PI / 2);
    send_beat(MAX_C, 0, MIN_C, 0, ONE_Q16, 0, ANG_HALF_PI / 2);
    send_beat(MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C, MIN_C);
    send_beat(MAX_C, MIN_C, MAX_C, MAX_C, MAX_C, MAX_C, MAX_C);
    send_beat(ONE_Q16, 0, 0, 0, 0, 1, 0);
    send_beat(ONE_Q16, 0, 0, 0, 0, -1, ANG_PI);
    send_beat(ONE_Q16, 0, 0, 0, 0, ONE_Q16, -ANG_PI);
    send_beat(0, ONE_Q16, 0, ONE_Q16, 0, 0, ANG_HALF_PI);
    send_beat(0, ONE_Q16, 0, ONE_Q16, 0, 0, -ANG_HALF_PI);
    send_beat(ONE_Q16, ONE_Q16, 0, MIN_C, 0, 0, ANG_HALF_PI + 1);
    send_beat(ONE_Q16, 2, -3, MAX_C, 1, 0, ANG_PI + 1);
    send_beat(-ONE_Q16, 5, 7, 1, 1, 1, -ANG_PI - 1);
    send_beat(MAX_C, MAX_C, 0, 3, -4, 5, 32'sh40000000);
    send_beat(0, 0, 0, 12345, 678, -9, 32'sh12345678);
    send_beat(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 32'shf0f0f0f0,
              32'sh33333333, 32'shcccccccc, 32'sh5a5a5a5a);

    for (int n = 0; n < RANDOM_BEATS; n++) begin
      mode = $urandom_range(9);
      if (mode == 9) begin
        send_beat($urandom, $urandom, $urandom, 0, 0, 0, $urandom);
      end else begin
        send_beat($urandom, $urandom, $urandom,
                  rand_axis(mode % 3), rand_axis((mode + 1) % 3),
                  rand_axis(mode < 3 ? 0 : $urandom_range(3)), $urandom);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: axis_angle_vector_rotation.f
rtl/aavr_pkg.sv
rtl/aavr_norm_cell.sv
rtl/aavr_sqrt_cell.sv
rtl/aavr_div_cell.sv
rtl/aavr_cordic_cell.sv
rtl/axis_angle_vector_rotation.sv
tb/rotation_checker.sv
tb/tb_axis_angle_vector_rotation.sv
